// ----- rtl/eftr_pkg.sv -----
// ---------------------------------------------------------------------------
// eftr_pkg
// Shared types and codes for the edge-function triangle rasterizer.
// ---------------------------------------------------------------------------
package eftr_pkg;

  // request kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // scan control toward the output stage
  typedef struct packed {
    logic emit;   // a position result is produced this cycle
    logic last;   // it is the final box position
  } scan_ctl_t;

endpackage

// ----- rtl/edge_function_triangle_rasterizer.sv -----
// ---------------------------------------------------------------------------
// edge_function_triangle_rasterizer
// A step result passes the combinational edge test into the output register,
//   or into the skid entry while that register is stalled. Throughput: one
//   request per cycle while the skid entry is free; one box position per step during a scan.
// Reset: synchronous; scan goes idle, triangle, box and cursor clear to zero.
// ---------------------------------------------------------------------------
module edge_function_triangle_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] vert_a_x,
  input  logic signed [COORD_BITS-1:0] vert_a_y,
  input  logic signed [COORD_BITS-1:0] vert_b_x,
  input  logic signed [COORD_BITS-1:0] vert_b_y,
  input  logic signed [COORD_BITS-1:0] vert_c_x,
  input  logic signed [COORD_BITS-1:0] vert_c_y,
  input  logic        [COLOR_BITS-1:0] fill_color,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic        [COLOR_BITS-1:0] pixel_color,
  output logic                         covered,
  output logic                         last
);

  localparam int RW = 2 * COORD_BITS + COLOR_BITS + 2;

  logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic        [COLOR_BITS-1:0] color;
  eftr_pkg::scan_ctl_t          ctl;
  logic                         fire;
  logic                         s_ab, s_bc, s_ca;
  logic                         in_tri;
  logic [RW-1:0]                res_data, out_data;

  // a request is taken whenever the skid entry is free
  assign fire = in_valid && in_ready;

  eftr_scan_ctrl #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .kind      (kind),
    .vert_a_x  (vert_a_x),
    .vert_a_y  (vert_a_y),
    .vert_b_x  (vert_b_x),
    .vert_b_y  (vert_b_y),
    .vert_c_x  (vert_c_x),
    .vert_c_y  (vert_c_y),
    .fill_color(fill_color),
    .a_x       (a_x),
    .a_y       (a_y),
    .b_x       (b_x),
    .b_y       (b_y),
    .c_x       (c_x),
    .c_y       (c_y),
    .color     (color),
    .cursor_x  (cur_x),
    .cursor_y  (cur_y),
    .ctl       (ctl)
  );

  // edge tests at the cursor for edges ab, bc and ca, all in parallel
  eftr_edge_sign #(.COORD_BITS(COORD_BITS)) u_edge_ab (
    .u_x(a_x), .u_y(a_y), .v_x(b_x), .v_y(b_y),
    .p_x(cur_x), .p_y(cur_y), .neg(s_ab)
  );

  eftr_edge_sign #(.COORD_BITS(COORD_BITS)) u_edge_bc (
    .u_x(b_x), .u_y(b_y), .v_x(c_x), .v_y(c_y),
    .p_x(cur_x), .p_y(cur_y), .neg(s_bc)
  );

  eftr_edge_sign #(.COORD_BITS(COORD_BITS)) u_edge_ca (
    .u_x(c_x), .u_y(c_y), .v_x(a_x), .v_y(a_y),
    .p_x(cur_x), .p_y(cur_y), .neg(s_ca)
  );

  // covered when all three signs agree (either winding)
  assign in_tri   = (s_ab == s_bc) && (s_bc == s_ca);
  assign res_data = {cur_x, cur_y, color, in_tri, ctl.last};

  eftr_out_buf #(.WIDTH(RW)) u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (ctl.emit),
    .push_data(res_data),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign {pixel_x, pixel_y, pixel_color, covered, last} = out_data;

endmodule

// ----- rtl/eftr_edge_sign.sv -----
// ---------------------------------------------------------------------------
// eftr_edge_sign
// Sign of one edge function det(p,u,v) = (u-p) x (v-p), exact width.
// ---------------------------------------------------------------------------
module eftr_edge_sign #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] u_x,
  input  logic signed [COORD_BITS-1:0] u_y,
  input  logic signed [COORD_BITS-1:0] v_x,
  input  logic signed [COORD_BITS-1:0] v_y,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  output logic                         neg
);

  localparam int DW = COORD_BITS + 1;   // coordinate difference
  localparam int PW = 2 * DW;           // product
  localparam int EW = PW + 1;           // difference of products

  logic signed [DW-1:0] dux, duy, dvx, dvy;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [EW-1:0] edge_val;

  assign dux = DW'(u_x) - DW'(p_x);
  assign duy = DW'(u_y) - DW'(p_y);
  assign dvx = DW'(v_x) - DW'(p_x);
  assign dvy = DW'(v_y) - DW'(p_y);

  assign prod_a = PW'(dux) * PW'(dvy);
  assign prod_b = PW'(duy) * PW'(dvx);

  assign edge_val = EW'(prod_a) - EW'(prod_b);
  assign neg      = edge_val[EW-1];

endmodule

// ----- rtl/eftr_scan_ctrl.sv -----
// ---------------------------------------------------------------------------
// eftr_scan_ctrl
// Holds triangle, bounding box and cursor; walks the box one position per step request while active.
// ---------------------------------------------------------------------------
module eftr_scan_ctrl #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] vert_a_x,
  input  logic signed [COORD_BITS-1:0] vert_a_y,
  input  logic signed [COORD_BITS-1:0] vert_b_x,
  input  logic signed [COORD_BITS-1:0] vert_b_y,
  input  logic signed [COORD_BITS-1:0] vert_c_x,
  input  logic signed [COORD_BITS-1:0] vert_c_y,
  input  logic        [COLOR_BITS-1:0] fill_color,
  output logic signed [COORD_BITS-1:0] a_x,
  output logic signed [COORD_BITS-1:0] a_y,
  output logic signed [COORD_BITS-1:0] b_x,
  output logic signed [COORD_BITS-1:0] b_y,
  output logic signed [COORD_BITS-1:0] c_x,
  output logic signed [COORD_BITS-1:0] c_y,
  output logic        [COLOR_BITS-1:0] color,
  output logic signed [COORD_BITS-1:0] cursor_x,
  output logic signed [COORD_BITS-1:0] cursor_y,
  output eftr_pkg::scan_ctl_t          ctl
);

  // x min only seeds the cursor at load, so it is not kept
  logic signed [COORD_BITS-1:0] x_max, y_min, y_max;
  logic signed [COORD_BITS-1:0] ld_x_min, ld_x_max, ld_y_min, ld_y_max;
  logic signed [COORD_BITS-1:0] m0, m1, m2, m3;
  logic                         active;
  logic                         do_load;
  logic                         y_wrap, x_done;

  // box of the incoming triangle
  always_comb begin
    m0 = (vert_a_x < vert_b_x) ? vert_a_x : vert_b_x;
    ld_x_min = (m0 < vert_c_x) ? m0 : vert_c_x;
    m1 = (vert_a_x > vert_b_x) ? vert_a_x : vert_b_x;
    ld_x_max = (m1 > vert_c_x) ? m1 : vert_c_x;
    m2 = (vert_a_y < vert_b_y) ? vert_a_y : vert_b_y;
    ld_y_min = (m2 < vert_c_y) ? m2 : vert_c_y;
    m3 = (vert_a_y > vert_b_y) ? vert_a_y : vert_b_y;
    ld_y_max = (m3 > vert_c_y) ? m3 : vert_c_y;
  end

  assign do_load  = fire && (kind == eftr_pkg::KIND_LOAD);
  assign ctl.emit = fire && (kind == eftr_pkg::KIND_STEP) && active;
  assign y_wrap   = !(cursor_y < y_max);
  assign x_done   = !(cursor_x < x_max);
  assign ctl.last = y_wrap && x_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      cursor_x <= '0;
      cursor_y <= '0;
      x_max    <= '0;
      y_min    <= '0;
      y_max    <= '0;
      a_x      <= '0;
      a_y      <= '0;
      b_x      <= '0;
      b_y      <= '0;
      c_x      <= '0;
      c_y      <= '0;
      color    <= '0;
    end else if (do_load) begin
      a_x      <= vert_a_x;
      a_y      <= vert_a_y;
      b_x      <= vert_b_x;
      b_y      <= vert_b_y;
      c_x      <= vert_c_x;
      c_y      <= vert_c_y;
      color    <= fill_color;
      x_max    <= ld_x_max;
      y_min    <= ld_y_min;
      y_max    <= ld_y_max;
      cursor_x <= ld_x_min;
      cursor_y <= ld_y_min;
      active   <= 1'b1;
    end else if (ctl.emit) begin
      if (!y_wrap) begin
        cursor_y <= cursor_y + COORD_BITS'(1);
      end else begin
        cursor_y <= y_min;
        if (!x_done) begin
          cursor_x <= cursor_x + COORD_BITS'(1);
        end else begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/eftr_out_buf.sv -----
// ---------------------------------------------------------------------------
// eftr_out_buf
// Output register plus skid entry; decouples ready from the downstream side.
// ---------------------------------------------------------------------------
module eftr_out_buf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] skid_data;
  logic             skid_valid;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge-function triangle rasterizer. A request
// queue filled at time zero feeds a clocked driver; a clocked monitor
// predicts every accepted request and checks each pixel result in order.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int CB = 12;
  localparam int LB = 32;
  localparam int TARGET_REQS = 1750;

  // one request as it sits on the input ports
  typedef struct packed {
    logic                 kind;
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
    logic        [LB-1:0] color;
  } req_t;

  // one pixel result as it sits on the output ports
  typedef struct packed {
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic        [LB-1:0] color;
    logic                 cov;
    logic                 fin;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  req_t cur_req = '0;

  logic signed [CB-1:0] pixel_x, pixel_y;
  logic        [LB-1:0] pixel_color;
  logic                 covered, last;

  req_t   req_q[$];        // requests not yet offered
  pixel_t pending_pix[$];  // predicted pixels not yet seen
  int     total_reqs = 0;
  int     sent_reqs = 0;
  int     err_count = 0;
  logic   req_taken = 1'b0;

  always #5 clk = ~clk;

  edge_function_triangle_rasterizer #(
    .COORD_BITS(CB),
    .COLOR_BITS(LB)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (cur_req.kind),
    .vert_a_x   (cur_req.ax),
    .vert_a_y   (cur_req.ay),
    .vert_b_x   (cur_req.bx),
    .vert_b_y   (cur_req.by),
    .vert_c_x   (cur_req.cx),
    .vert_c_y   (cur_req.cy),
    .fill_color (cur_req.color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .covered    (covered),
    .last       (last)
  );

  // -------------------------------------------------------------------------
  // Predictor state: our own copy of the triangle, box and scan cursor
  // -------------------------------------------------------------------------
  int            tri_x[3], tri_y[3];
  logic [LB-1:0] tri_color = '0;
  int            box_x0 = 0, box_x1 = 0, box_y0 = 0, box_y1 = 0;
  int            scan_x = 0, scan_y = 0;
  bit            scan_on = 1'b0;

  initial begin
    for (int i = 0; i < 3; i++) begin
      tri_x[i] = 0;
      tri_y[i] = 0;
    end
  end

  function automatic int min3(int a, int b, int c);
    int m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic int max3(int a, int b, int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // twice the signed area of (u-p, v-p); 64 bits leaves lots of headroom
  function automatic longint edge_val(int px, int py, int ux, int uy, int vx, int vy);
    return longint'(ux - px) * longint'(vy - py) - longint'(uy - py) * longint'(vx - px);
  endfunction

  // Apply one accepted request to the predictor; a step during a scan
  // queues the pixel it must produce.
  task automatic rasterize_request(req_t r);
    pixel_t p;
    bit     s0, s1, s2;
    if (r.kind == eftr_pkg::KIND_LOAD) begin
      // a load always restarts, even mid-scan
      tri_x[0] = $signed(r.ax); tri_y[0] = $signed(r.ay);
      tri_x[1] = $signed(r.bx); tri_y[1] = $signed(r.by);
      tri_x[2] = $signed(r.cx); tri_y[2] = $signed(r.cy);
      tri_color = r.color;
      box_x0 = min3(tri_x[0], tri_x[1], tri_x[2]);
      box_x1 = max3(tri_x[0], tri_x[1], tri_x[2]);
      box_y0 = min3(tri_y[0], tri_y[1], tri_y[2]);
      box_y1 = max3(tri_y[0], tri_y[1], tri_y[2]);
      scan_x = box_x0;
      scan_y = box_y0;
      scan_on = 1'b1;
    end else if (scan_on) begin
      // inside when all three "edge < 0" tests agree; zero counts as not
      // negative, so degenerate triangles need no special handling
      s0 = edge_val(scan_x, scan_y, tri_x[0], tri_y[0], tri_x[1], tri_y[1]) < 0;
      s1 = edge_val(scan_x, scan_y, tri_x[1], tri_y[1], tri_x[2], tri_y[2]) < 0;
      s2 = edge_val(scan_x, scan_y, tri_x[2], tri_y[2], tri_x[0], tri_y[0]) < 0;
      p.px    = CB'(scan_x);
      p.py    = CB'(scan_y);
      p.color = tri_color;
      p.cov   = (s0 == s1) && (s1 == s2);
      p.fin   = 1'b0;
      // y inner loop, x outer loop
      if (scan_y < box_y1) begin
        scan_y++;
      end else begin
        scan_y = box_y0;
        if (scan_x < box_x1) begin
          scan_x++;
        end else begin
          p.fin   = 1'b1;
          scan_on = 1'b0;
        end
      end
      pending_pix.push_back(p);
    end
    // step while idle: nothing happens
  endtask

  // -------------------------------------------------------------------------
  // Monitor: sample at the rising edge, predict accepted requests, check
  // accepted pixels against the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst) begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        rasterize_request(cur_req);
      if (out_valid && out_ready) begin
        got = '{pixel_x, pixel_y, pixel_color, covered, last};
        if (pending_pix.size() == 0) begin
          err_count++;
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h covered=%b last=%b",
                   $time, got.px, got.py, got.color, got.cov, got.fin);
        end else begin
          want = pending_pix.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: pixel mismatch exp x=%0d y=%0d color=%h covered=%b last=%b",
                     $time, want.px, want.py, want.color, want.cov, want.fin);
            $display("%0t:                act x=%0d y=%0d color=%h covered=%b last=%b",
                     $time, got.px, got.py, got.color, got.cov, got.fin);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Driver: change inputs at the falling edge. Three idling phases by
  // progress through the queue: light sender / heavy receiver stalls,
  // then the reverse, then none at all.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    req_t r;
    int   phase;
    int   send_idle, recv_idle;
    if (!rst) begin
      phase = (total_reqs > 0) ? (sent_reqs * 3) / total_reqs : 2;
      case (phase)
        0: begin
          send_idle = 7;
          recv_idle = 79;
        end
        1: begin
          send_idle = 79;
          recv_idle = 7;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      // only move on once the current request has gone through
      if (!in_valid || req_taken) begin
        if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          r = req_q.pop_front();
          cur_req  <= r;
          in_valid <= 1'b1;
          sent_reqs++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus generation. gen_left tracks how many box positions the current
  // scan still has, so we know which steps will actually produce a pixel.
  // -------------------------------------------------------------------------
  int gen_left = 0;
  int gen_count = 0;  // loads plus steps that land inside a scan

  function automatic longint box_positions(req_t r);
    int x0, x1, y0, y1;
    x0 = min3($signed(r.ax), $signed(r.bx), $signed(r.cx));
    x1 = max3($signed(r.ax), $signed(r.bx), $signed(r.cx));
    y0 = min3($signed(r.ay), $signed(r.by), $signed(r.cy));
    y1 = max3($signed(r.ay), $signed(r.by), $signed(r.cy));
    return longint'(x1 - x0 + 1) * longint'(y1 - y0 + 1);
  endfunction

  task automatic add_load(int ax, int ay, int bx, int by, int cx, int cy,
                          logic [LB-1:0] col);
    req_t r;
    r.kind  = eftr_pkg::KIND_LOAD;
    r.ax    = CB'(ax); r.ay = CB'(ay);
    r.bx    = CB'(bx); r.by = CB'(by);
    r.cx    = CB'(cx); r.cy = CB'(cy);
    r.color = col;
    req_q.push_back(r);
    // huge boxes are only ever partly scanned, the clamp is harmless
    gen_left = (box_positions(r) > 64'd1000000) ? 1000000 : int'(box_positions(r));
    gen_count++;
  endtask

  // vertex and color fields of a step are don't-care; randomize them
  task automatic add_steps(int n);
    req_t r;
    repeat (n) begin
      r = {$urandom, $urandom, $urandom, 9'($urandom)};
      r.kind = eftr_pkg::KIND_STEP;
      req_q.push_back(r);
      if (gen_left > 0) begin
        gen_left--;
        gen_count++;
      end
    end
  endtask

  // random triangle inside a span x span box placed anywhere in range
  task automatic add_rand_tri(int span);
    int bx0, by0;
    bx0 = int'($urandom_range(0, 4095 - span)) - 2048;
    by0 = int'($urandom_range(0, 4095 - span)) - 2048;
    add_load(bx0 + int'($urandom_range(0, span)), by0 + int'($urandom_range(0, span)),
             bx0 + int'($urandom_range(0, span)), by0 + int'($urandom_range(0, span)),
             bx0 + int'($urandom_range(0, span)), by0 + int'($urandom_range(0, span)),
             $urandom);
  endtask

  initial begin
    int sel, dx, dy, bx0, by0;

    // --- directed ---
    add_steps(1);                                        // step before any load
    add_load(5, -3, 5, -3, 5, -3, '0);                   // single-point box
    add_steps(1);
    add_load(2047, 2047, 2045, 2047, 2047, 2045, '1);    // top corner of range
    add_steps(9);
    add_load(-2048, -2048, 2047, -2048, -2048, 2047, 32'h5a5a_a5a5);
    add_steps(2);                                        // full-range box, cut short
    add_load(-2048, -2048, -2047, -2047, -2046, -2046, 32'h0f0f_f0f0);  // collinear
    add_steps(9);
    add_steps(1);                                        // step after the scan ended

    // --- random ---
    while (gen_count < TARGET_REQS) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        add_rand_tri($urandom_range(0, 6));
        add_steps(gen_left);
      end else if (sel < 70) begin
        add_rand_tri($urandom_range(7, 12));
        add_steps(gen_left);
      end else if (sel < 80) begin
        // degenerate: evenly spaced collinear points, or a single point
        dx  = int'($urandom_range(0, 4)) - 2;
        dy  = int'($urandom_range(0, 4)) - 2;
        bx0 = int'($urandom_range(4, 4091)) - 2048;
        by0 = int'($urandom_range(4, 4091)) - 2048;
        add_load(bx0, by0, bx0 + dx, by0 + dy, bx0 + 2 * dx, by0 + 2 * dy, $urandom);
        add_steps(gen_left);
      end else if (sel < 88) begin
        // wide-open vertices: scan only the first few positions
        add_load(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                 int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                 int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                 $urandom);
        add_steps($urandom_range(0, 5));
      end else if (sel < 95) begin
        // small triangle abandoned partway by the next load
        add_rand_tri($urandom_range(1, 6));
        if (gen_left > 1)
          add_steps($urandom_range(0, gen_left - 1));
      end else begin
        // noise: steps with no scan running (or finishing a partial one)
        add_steps($urandom_range(1, 3));
      end
    end
    total_reqs = req_q.size();

    // hold reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain: all requests accepted, every pixel seen, then a short quiet time
    while (req_q.size() > 0 || in_valid) @(posedge clk);
    while (pending_pix.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_count == 0 && pending_pix.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/eftr_pkg.sv
rtl/eftr_edge_sign.sv
rtl/eftr_scan_ctrl.sv
rtl/eftr_out_buf.sv
rtl/edge_function_triangle_rasterizer.sv
dv/tb_top.sv
